### src/dfs_tree_edge_union_assert.svh
// assertion macros for the dfs tree edge union block
`ifndef DFS_TREE_EDGE_UNION_ASSERT_SVH
`define DFS_TREE_EDGE_UNION_ASSERT_SVH

// property checked on every clock edge outside reset
`define DTEU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define DTEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### src/dteu_pkg.sv
// package: widths, beat types and helper functions for the dfs tree edge union block
package dteu_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W            = 6;
  localparam int ROW_W            = 64;
  localparam int VCOUNT_W         = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [VTX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } dteu_in_t;

  typedef struct packed {
    logic [VTX_W-1:0] source_vertex;
    logic [ROW_W-1:0] target_mask;
    logic             no_solution;
    logic             last;
  } dteu_out_t;

  // index of lowest set bit, 63 when none
  function automatic logic [VTX_W-1:0] lowest_bit(input logic [ROW_W-1:0] x);
    logic [VTX_W-1:0] k;
    k = VTX_W'(ROW_W - 1);
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (x[i]) k = VTX_W'(i);
    end
    return k;
  endfunction

endpackage

### src/dteu_ram.sv
// generic single write port ram with registered read
module dteu_ram
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
)
(
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/dfs_tree_edge_union.sv
// top level: depth-first spanning tree edge union over a loaded adjacency matrix
//
// Usage: rows are sent as command beats on item_i, one row per beat, taken
// when start is high and busy is low. The beat whose row_index equals
// vertex_count-1 starts a run: a depth-first search is made from every
// vertex in use, in turn, over the stored rows, stopping early if a search does
// not reach every vertex. Each search step reads the adjacency and edge rows
// from ram (S_READ), then writes the update back (S_STEP); a backtrack adds
// a stack ram read (S_POP). Busy stays high for the whole run and drops as
// the final beat appears. Results leave as beats on result_o, each valid for
// one cycle with result_valid_o, after an edge ram read (S_ORD) per source
// vertex. Either one no-solution beat, or n beats in source order with last
// on the final one. The receiver cannot stall; beats are not held.
// vertex_count is written through cfg_we_i / cfg_wdata_i, by the user only
// while idle; the block itself does not enforce this. Reset clears control
// state and sets vertex_count to 64; stored rows stay undefined until written.
module dfs_tree_edge_union
  import dteu_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dteu_in_t            item_i,
  output logic                result_valid_o,
  output dteu_out_t           result_o,
  input  logic                cfg_we_i,
  input  logic [VCOUNT_W-1:0] cfg_wdata_i
);

  `include "dfs_tree_edge_union_assert.svh"

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam logic [VCOUNT_W-1:0] MaxCount = VCOUNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_READ, S_STEP, S_POP, S_ORD, S_OEM
  } state_e;

  state_e                  state_q, state_d;
  logic [VCOUNT_W-1:0]     vc_q, vc_d;
  logic [DW-1:0]           s_q, s_d;
  logic [AW-1:0]           top_q, top_d;
  logic [DW-1:0]           depth_q, depth_d;
  logic [ROW_W-1:0]        visited_q, visited_d;
  logic [MAX_VERTICES-1:0] euv_q, euv_d;
  dteu_out_t               res_q, res_d;
  logic                    rv_q, rv_d;

  logic                    adj_we;
  logic [AW-1:0]           adj_waddr;
  logic [ROW_W-1:0]        adj_rdata;
  logic                    eu_we;
  logic [ROW_W-1:0]        eu_wdata;
  logic [AW-1:0]           eu_raddr;
  logic [ROW_W-1:0]        eu_rdata;
  logic                    stk_we;
  logic [AW-1:0]           stk_waddr;
  logic [AW-1:0]           stk_wdata;
  logic [AW-1:0]           stk_raddr;
  logic [AW-1:0]           stk_rdata;

  logic [VCOUNT_W-1:0]     n_w;
  logic [ROW_W-1:0]        all_w;
  logic [ROW_W-1:0]        cand;
  logic [VTX_W-1:0]        v_w;
  logic [ROW_W-1:0]        bit_w;
  logic [ROW_W-1:0]        eu_top;
  logic [ROW_W-1:0]        eu_src;
  logic                    row_ok;
  logic                    s_last;
  logic [DW-1:0]           depth_m2;

  assign n_w = (vc_q == '0) ? VCOUNT_W'(1) : ((vc_q > MaxCount) ? MaxCount : vc_q);
  assign all_w    = ~({ROW_W{1'b1}} << n_w);
  assign cand     = adj_rdata & all_w & ~visited_q;
  assign v_w      = lowest_bit(cand);
  assign bit_w    = ROW_W'(1) << v_w;
  assign eu_top   = euv_q[top_q] ? eu_rdata : '0;
  assign eu_src   = euv_q[s_q[AW-1:0]] ? eu_rdata : '0;
  assign row_ok   = VCOUNT_W'(item_i.row_index) < MaxCount;
  assign s_last   = (VCOUNT_W'(s_q) + VCOUNT_W'(1)) == n_w;
  assign depth_m2 = depth_q - DW'(2);

  assign adj_we    = (state_q == S_IDLE) && start && row_ok;
  assign adj_waddr = item_i.row_index[AW-1:0];
  assign eu_wdata  = eu_top | bit_w;
  assign eu_we     = (state_q == S_STEP) && (cand != '0);
  assign eu_raddr  = (state_q == S_ORD) ? s_q[AW-1:0] : top_q;
  assign stk_raddr = depth_m2[AW-1:0];

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = depth_q[AW-1:0];
    stk_wdata = v_w[AW-1:0];
    if (state_q == S_ROOT) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = s_q[AW-1:0];
    end else if (eu_we && (depth_q < DW'(MAX_VERTICES))) begin
      stk_we = 1'b1;
    end
  end

  dteu_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (item_i.row_bits),
    .raddr_i (top_q),
    .rdata_o (adj_rdata)
  );

  dteu_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_eu_ram (
    .clk_i   (clk_i),
    .we_i    (eu_we),
    .waddr_i (top_q),
    .wdata_i (eu_wdata),
    .raddr_i (eu_raddr),
    .rdata_o (eu_rdata)
  );

  dteu_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    state_d   = state_q;
    vc_d      = cfg_we_i ? cfg_wdata_i : vc_q;
    s_d       = s_q;
    top_d     = top_q;
    depth_d   = depth_q;
    visited_d = visited_q;
    euv_d     = euv_q;
    res_d     = res_q;
    rv_d      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start && row_ok &&
            (VCOUNT_W'(item_i.row_index) + VCOUNT_W'(1)) == n_w) begin
          euv_d   = '0;
          s_d     = '0;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        visited_d = ROW_W'(1) << s_q;
        top_d     = s_q[AW-1:0];
        depth_d   = DW'(1);
        state_d   = S_READ;
      end
      S_READ: state_d = S_STEP;
      S_STEP: begin
        if (cand != '0) begin
          euv_d[top_q] = 1'b1;
          visited_d    = visited_q | bit_w;
          if (depth_q < DW'(MAX_VERTICES)) begin
            depth_d = depth_q + DW'(1);
            top_d   = v_w[AW-1:0];
          end
          state_d = S_READ;
        end else if (depth_q == DW'(1)) begin
          depth_d = '0;
          if (visited_q != all_w) begin
            res_d   = '{source_vertex: '0, target_mask: '0, no_solution: 1'b1, last: 1'b1};
            rv_d    = 1'b1;
            state_d = S_IDLE;
          end else if (s_last) begin
            s_d     = '0;
            state_d = S_ORD;
          end else begin
            s_d     = s_q + DW'(1);
            state_d = S_ROOT;
          end
        end else begin
          depth_d = depth_q - DW'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        top_d   = stk_rdata;
        state_d = S_READ;
      end
      S_ORD: state_d = S_OEM;
      S_OEM: begin
        res_d = '{source_vertex: VTX_W'(s_q), target_mask: eu_src,
                  no_solution: 1'b0, last: s_last};
        rv_d  = 1'b1;
        if (s_last) begin
          state_d = S_IDLE;
        end else begin
          s_d     = s_q + DW'(1);
          state_d = S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vc_q      <= VCOUNT_RESET;
      s_q       <= '0;
      top_q     <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      euv_q     <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      vc_q      <= vc_d;
      s_q       <= s_d;
      top_q     <= top_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      euv_q     <= euv_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  `DTEU_ASSERT(a_depth_bound, clk_i, rst_ni, depth_q <= DW'(MAX_VERTICES), "stack depth overflow")
  `DTEU_ASSERT_IMPL(a_last_idle, clk_i, rst_ni, rv_q && res_q.last, !busy, "busy after last beat")
  `DTEU_ASSERT_IMPL(a_nosol_last, clk_i, rst_ni, rv_q && res_q.no_solution, res_q.last, "no-solution beat not last")
  `DTEU_ASSERT_IMPL(a_step_depth, clk_i, rst_ni, state_q == S_STEP, depth_q != '0, "search step with empty stack")

endmodule
